### sv/otb_pkg.sv
`default_nettype none
package otb_pkg;

  localparam int unsigned GRAY_BITS = 8;
  localparam int unsigned BIN_COUNT = 256;
  localparam int unsigned ADDR_BITS = 8;

  // Fixed-point luma weights with eight fraction bits.
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd151;
  localparam logic [7:0] LUMA_B = 8'd28;

  localparam logic       REG_USE_FIXED   = 1'b0;
  localparam logic       REG_FIXED_LEVEL = 1'b1;
  localparam logic [7:0] FIXED_LEVEL_RST = 8'd127;

  localparam logic KIND_ACCUMULATE = 1'b0;
  localparam logic KIND_CLASSIFY   = 1'b1;

  // Operations run on the shared shift-and-add multiplier.
  typedef enum logic [2:0] {
    MOP_SN,   // S1 * N
    MOP_SG,   // S * n1, then absolute difference
    MOP_SQ,   // difference squared
    MOP_DEN,  // n1 * n2
    MOP_LHS,  // candidate numerator * best denominator
    MOP_RHS   // best numerator * candidate denominator
  } mop_t;

  typedef struct packed {
    logic take_item;
    logic wr_acc;
    logic sweep_init;
    logic upd_sweep;
    logic next_k;
    logic clr_init;
    logic wr_clr;
    logic mul_start;
    mop_t mul_op;
    logic load_cls;
    logic load_rep;
  } otb_cmd_t;

  typedef struct packed {
    logic kind;
    logic last;
    logic n_zero;
    logic have;
    logic k_end;
    logic clr_end;
    logic mul_done;
    logic out_free;
  } otb_sts_t;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [15:0] sum;
    sum = 16'(r) * 16'(LUMA_R) + 16'(g) * 16'(LUMA_G) + 16'(b) * 16'(LUMA_B);
    return sum[15:8];
  endfunction

endpackage
`default_nettype wire

### sv/otb_mul.sv
`default_nettype none
module otb_mul #(
  parameter int unsigned A_BITS = 196,
  parameter int unsigned B_BITS = 68
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [A_BITS-1:0] a,
  input  wire logic [B_BITS-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [A_BITS-1:0]      prod
);

  localparam int unsigned CNT_W = $clog2(B_BITS + 1);

  logic [A_BITS-1:0] a_r;
  logic [A_BITS-1:0] acc_r;
  logic [B_BITS-1:0] b_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;

  // One multiplier bit per cycle; the product is truncated to A_BITS.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      a_r    <= a;
      b_r    <= b;
      acc_r  <= '0;
      cnt_r  <= CNT_W'(B_BITS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r    <= a_r << 1;
      b_r    <= b_r >> 1;
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

### sv/otb_dp.sv
`default_nettype none
module otb_dp import otb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire otb_cmd_t    cmd,
  output otb_sts_t         sts,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tuser
);

  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned NW   = CW + 8;
  localparam int unsigned SW   = CW + 16;
  localparam int unsigned MB   = 2 * CW + 24;
  localparam int unsigned DENW = 2 * CW + 16;
  localparam int unsigned NUMW = 4 * CW + 48;
  localparam int unsigned PW   = 6 * CW + 64;

  logic [CW-1:0]        mem [BIN_COUNT];
  logic [CW-1:0]        rd_data_r;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [CW-1:0]        mem_wdata;
  logic                 mem_we;
  logic                 sat;

  logic [7:0]           gray_in;
  logic [7:0]           gray_r;
  logic                 kind_r;
  logic                 last_r;
  logic                 use_fixed_r;
  logic [7:0]           fixed_r;
  logic [7:0]           stored_r;

  logic [ADDR_BITS-1:0] k_r;
  logic [NW-1:0]        n_all_r;
  logic [SW-1:0]        s_all_r;
  logic [NW-1:0]        n1_r;
  logic [SW-1:0]        s1_r;
  logic [NW-1:0]        n2;

  logic [MB-1:0]        x_r;
  logic [MB-1:0]        diff_r;
  logic [NUMW-1:0]      num_r;
  logic [DENW-1:0]      den_r;
  logic [PW-1:0]        lhs_r;
  logic [NUMW-1:0]      best_num_r;
  logic [DENW-1:0]      best_den_r;
  logic [7:0]           best_t_r;
  logic                 have_r;
  mop_t                 mop_r;

  logic [PW-1:0]        mul_a;
  logic [MB-1:0]        mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic [PW-1:0]        prod;
  logic [MB-1:0]        y;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [7:0]           out_thr_r;
  logic [7:0]           out_gray_r;
  logic                 out_bit_r;
  logic                 out_free;

  assign gray_in = luma(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);

  // Histogram memory: one read and one write port, registered read.
  assign sat       = (rd_data_r == {CW{1'b1}});
  assign mem_raddr = cmd.take_item ? gray_in : k_r;
  assign mem_we    = (cmd.wr_acc && !sat) || cmd.wr_clr;
  assign mem_waddr = cmd.wr_clr ? k_r : gray_r;
  assign mem_wdata = cmd.wr_clr ? '0 : rd_data_r + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      gray_r <= gray_in;
      kind_r <= in_tuser;
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_fixed_r <= 1'b0;
      fixed_r     <= FIXED_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_FIXED:   use_fixed_r <= cfg_wdata[0];
        REG_FIXED_LEVEL: fixed_r     <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Running totals follow the histogram exactly, saturated bins included.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      n_all_r <= '0;
      s_all_r <= '0;
    end else begin
      if (cmd.clr_init || cmd.sweep_init) begin
        k_r <= '0;
      end else if (cmd.next_k || cmd.wr_clr) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.wr_clr) begin
        n_all_r <= '0;
        s_all_r <= '0;
      end else if (cmd.wr_acc && !sat) begin
        n_all_r <= n_all_r + 1'b1;
        s_all_r <= s_all_r + SW'(gray_r);
      end
    end
  end

  assign n2 = n_all_r - n1_r;

  always_comb begin
    case (cmd.mul_op)
      MOP_SN:  begin mul_a = PW'(s1_r);       mul_b = MB'(n_all_r);    end
      MOP_SG:  begin mul_a = PW'(s_all_r);    mul_b = MB'(n1_r);       end
      MOP_SQ:  begin mul_a = PW'(diff_r);     mul_b = diff_r;          end
      MOP_DEN: begin mul_a = PW'(n1_r);       mul_b = MB'(n2);         end
      MOP_LHS: begin mul_a = PW'(num_r);      mul_b = MB'(best_den_r); end
      MOP_RHS: begin mul_a = PW'(best_num_r); mul_b = MB'(den_r);      end
      default: begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  otb_mul #(
    .A_BITS(PW),
    .B_BITS(MB)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .done (mul_done),
    .prod (prod)
  );

  assign y = prod[MB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      best_t_r <= '0;
      n1_r     <= '0;
      s1_r     <= '0;
      mop_r    <= MOP_SN;
    end else begin
      if (cmd.mul_start) begin
        mop_r <= cmd.mul_op;
      end
      if (cmd.sweep_init) begin
        have_r   <= 1'b0;
        best_t_r <= '0;
        n1_r     <= '0;
        s1_r     <= '0;
      end else if (cmd.upd_sweep) begin
        n1_r <= n1_r + NW'(rd_data_r);
        s1_r <= s1_r + SW'(k_r) * SW'(rd_data_r);
      end
      if (mul_done) begin
        case (mop_r)
          MOP_SN:  x_r    <= y;
          MOP_SG:  diff_r <= (x_r >= y) ? x_r - y : y - x_r;
          MOP_SQ:  num_r  <= prod[NUMW-1:0];
          MOP_DEN: begin
            den_r <= prod[DENW-1:0];
            if (!have_r) begin
              have_r     <= 1'b1;
              best_num_r <= num_r;
              best_den_r <= prod[DENW-1:0];
              best_t_r   <= k_r + 1'b1;
            end
          end
          MOP_LHS: lhs_r <= prod;
          MOP_RHS: begin
            if (lhs_r > prod) begin
              best_num_r <= num_r;
              best_den_r <= den_r;
              best_t_r   <= k_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      stored_r    <= '0;
    end else if (cmd.load_cls) begin
      out_valid_r <= 1'b1;
    end else if (cmd.load_rep) begin
      out_valid_r <= 1'b1;
      stored_r    <= best_t_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cls) begin
      out_kind_r <= KIND_CLASSIFY;
      out_thr_r  <= stored_r;
      out_gray_r <= gray_r;
      out_bit_r  <= use_fixed_r ? (gray_r >= fixed_r) : (gray_r < stored_r);
    end else if (cmd.load_rep) begin
      out_kind_r <= KIND_ACCUMULATE;
      out_thr_r  <= best_t_r;
      out_gray_r <= '0;
      out_bit_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_bit_r, out_gray_r, out_thr_r};

  assign sts.kind     = kind_r;
  assign sts.last     = last_r;
  assign sts.n_zero   = (n1_r == '0) || (n2 == '0);
  assign sts.have     = have_r;
  assign sts.k_end    = (k_r == ADDR_BITS'(BIN_COUNT - 2));
  assign sts.clr_end  = (k_r == ADDR_BITS'(BIN_COUNT - 1));
  assign sts.mul_done = mul_done;
  assign sts.out_free = out_free;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_acc && cmd.wr_clr)) else $error("histogram written by two sources");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_cls || cmd.load_rep) |-> out_free)
    else $error("result loaded over an item not yet taken");

endmodule
`default_nettype wire

### sv/otb_ctrl.sv
`default_nettype none
module otb_ctrl import otb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire otb_sts_t sts,
  output otb_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ACC_WR, S_CLS_OUT, S_SW_RD, S_SW_UPD, S_SW_CHK,
    S_MUL_GO, S_MUL_WAIT, S_NEXT_T, S_REP_OUT
  } state_t;

  state_t state_r, state_nxt;
  mop_t   op_r, op_nxt;
  logic   rep_r, rep_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    rep_nxt   = rep_r;
    cmd       = '0;
    cmd.mul_op = op_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.wr_clr = 1'b1;
        if (sts.clr_end) begin
          state_nxt = rep_r ? S_REP_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        if (sts.kind == KIND_CLASSIFY) begin
          state_nxt = S_CLS_OUT;
        end else begin
          cmd.wr_acc = 1'b1;
          if (sts.last) begin
            cmd.sweep_init = 1'b1;
            state_nxt = S_SW_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLS_OUT: begin
        if (sts.out_free) begin
          cmd.load_cls = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SW_RD:  state_nxt = S_SW_UPD;
      S_SW_UPD: begin
        cmd.upd_sweep = 1'b1;
        state_nxt = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (sts.n_zero) begin
          state_nxt = S_NEXT_T;
        end else begin
          op_nxt = MOP_SN;
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = S_MUL_GO;
          case (op_r)
            MOP_SN:  op_nxt = MOP_SG;
            MOP_SG:  op_nxt = MOP_SQ;
            MOP_SQ:  op_nxt = MOP_DEN;
            MOP_DEN: begin
              if (sts.have) begin
                op_nxt = MOP_LHS;
              end else begin
                state_nxt = S_NEXT_T;
              end
            end
            MOP_LHS: op_nxt = MOP_RHS;
            default: state_nxt = S_NEXT_T;
          endcase
        end
      end
      S_NEXT_T: begin
        if (sts.k_end) begin
          cmd.clr_init = 1'b1;
          rep_nxt = 1'b1;
          state_nxt = S_CLR;
        end else begin
          cmd.next_k = 1'b1;
          state_nxt = S_SW_RD;
        end
      end
      S_REP_OUT: begin
        if (sts.out_free) begin
          cmd.load_rep = 1'b1;
          rep_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      op_r    <= MOP_SN;
      rep_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/otsu_threshold_binarizer_top.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// in_       in         in_tvalid/in_tready   tdata red,green,blue; tuser kind; tlast last
// out_      out        out_tvalid/out_tready tdata threshold,gray,bit; tuser result kind
// cfg_      in         cfg_we                cfg_index register, cfg_wdata value
//
// An accumulate item passes an accept state and a write state before the next one is
// accepted; a classify item also passes an output state, which waits for the output register
// to be free. The item marked last runs the threshold sweep: per level a read, an update, a
// check and a next-level state plus, where both classes are filled, passes of the bit-serial
// multiplier (four on the first such level, six on every later one), and then a clearing pass
// through the histogram memory before the report is given.
// After reset the same clearing pass runs before the first item is accepted.
// Reset is synchronous and active low; a stalled output holds its item.
module otsu_threshold_binarizer_top import otb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  wire logic        in_tuser,   // kind
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // threshold [7:0], gray [15:8], bit [16], zeros
  output logic             out_tuser,  // result kind
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  otb_cmd_t cmd;
  otb_sts_t sts;

  // The controller sequences accumulation, the sweep and the clearing pass.
  otb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the histogram memory, the sums and the shared multiplier.
  otb_dp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire
